// ===== hdl/b32m_pkg.sv =====
`default_nettype none

package b32m_pkg;

   localparam int ACC_W    = 30;
   localparam int SYMBOL_W = 5;
   localparam int VALUE_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [ACC_W-1:0] GEN_POLY [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   localparam logic [ACC_W-1:0] ACC_INIT            = 30'd1;
   localparam logic [ACC_W-1:0] FINAL_CONSTANT_INIT = 30'h2bc830a3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_CONSTANT = 1'd1;

   localparam logic CMD_PREFIX  = 1'b0;
   localparam logic CMD_DATA    = 1'b1;
   localparam logic MODE_VERIFY = 1'b0;
   localparam logic MODE_CREATE = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/b32m_req_if.sv =====
`default_nettype none

interface b32m_req_if
   import b32m_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [VALUE_W-1:0] value;
   logic               last;

   modport source (output valid, cmd, value, last, input ready);
   modport sink   (input valid, cmd, value, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/b32m_rsp_if.sv =====
`default_nettype none

interface b32m_rsp_if
   import b32m_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                checksum_ok;
   logic                seq_error;
   logic                end_of_run;

   modport source (output valid, symbol, checksum_ok, seq_error, end_of_run, input ready);
   modport sink   (input valid, symbol, checksum_ok, seq_error, end_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/b32m_ram.sv =====
`default_nettype none

module b32m_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/b32m_fold.sv =====
`default_nettype none

module b32m_fold
   import b32m_pkg::*;
(
   input  wire logic [ACC_W-1:0]    acc,
   input  wire logic [SYMBOL_W-1:0] sym,
   output logic      [ACC_W-1:0]    acc_next
);

   always_comb begin
      acc_next = {acc[ACC_W-SYMBOL_W-1:0], sym};
      for (int k = 0; k < 5; k++) begin
         if (acc[ACC_W-SYMBOL_W+k]) begin
            acc_next = acc_next ^ GEN_POLY[k];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bech32m_checksum.sv =====
`default_nettype none

// Streaming Bech32 / Bech32m checksum engine. Send prefix characters (cmd 0),
// then 5-bit data symbols (cmd 1), with last set on the final word. Each word
// of the prefix or of the data phase passes through the single polymod fold
// unit. The first data word (or the end of a string without data) starts a
// zero fold and a replay of the stored low bits of the prefix through the one
// read port of the prefix RAM. At the end, verify mode gives one result word;
// create mode folds six zeros and then gives six symbol words, one per cycle
// while the receiver takes them. The input is not ready while the replay or
// the finish runs; the finish also holds it while an earlier result word
// waits to be taken. The final result word of a string may still wait in the
// output register while the next string is being accepted.
module bech32m_checksum
   import b32m_pkg::*;
#(
   parameter int MAX_PREFIX = 83
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   b32m_req_if.sink                  req,
   b32m_rsp_if.source                rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ACC_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(MAX_PREFIX + 1);
   localparam int AW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_ZERO, S_REPLAY, S_PEND, S_TAIL, S_EMIT
   } state_type;

   state_type           state_ff, state_in, finish_state;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic                data_ph_ff, data_ph_in;
   logic                err_ff, err_in;
   logic                pend_data_ff, pend_data_in;
   logic                pend_last_ff, pend_last_in;
   logic [VALUE_W-1:0]  pend_val_ff, pend_val_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic                mode_ff, mode_in;
   logic [ACC_W-1:0]    fc_ff, fc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic                ok_ff, ok_in;
   logic                serr_ff, serr_in;
   logic                eor_ff, eor_in;

   logic [SYMBOL_W-1:0] fold_sym;
   logic [ACC_W-1:0]    fold_out;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [SYMBOL_W-1:0] ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [SYMBOL_W-1:0] ram_rdata;
   logic                out_free;
   logic                eor;

   b32m_fold u_fold (
      .acc      (acc_ff),
      .sym      (fold_sym),
      .acc_next (fold_out)
   );

   b32m_ram #(
      .WIDTH (SYMBOL_W),
      .DEPTH (MAX_PREFIX),
      .AW    (AW)
   ) u_prefix_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      data_ph_in   = data_ph_ff;
      err_in       = err_ff;
      pend_data_in = pend_data_ff;
      pend_last_in = pend_last_ff;
      pend_val_in  = pend_val_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      fc_in        = fc_ff;
      sym_in       = sym_ff;
      ok_in        = ok_ff;
      serr_in      = serr_ff;
      eor_in       = eor_ff;
      fold_sym     = '0;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = req.value[SYMBOL_W-1:0];
      ram_raddr    = ptr_ff[AW-1:0];
      eor          = 1'b0;
      out_free     = !rsp_valid_ff || rsp.ready;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      finish_state = (mode_ff == MODE_CREATE) ? S_TAIL : S_EMIT;

      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[0];
            end
            CSR_FINAL_CONSTANT: begin
               fc_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               pend_val_in  = req.value;
               pend_last_in = req.last;
               if (req.cmd == CMD_PREFIX) begin
                  if (data_ph_ff || count_ff == CW'(MAX_PREFIX)) begin
                     err_in = 1'b1;
                  end else begin
                     fold_sym = {3'b000, req.value[VALUE_W-1:SYMBOL_W]};
                     acc_in   = fold_out;
                     ram_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  if (req.last) begin
                     pend_data_in = 1'b0;
                     state_in     = data_ph_ff ? finish_state : S_ZERO;
                  end
               end else if (!data_ph_ff) begin
                  pend_data_in = 1'b1;
                  state_in     = S_ZERO;
               end else begin
                  if (req.value[VALUE_W-1:SYMBOL_W] != 2'b00) begin
                     err_in = 1'b1;
                  end else begin
                     fold_sym = req.value[SYMBOL_W-1:0];
                     acc_in   = fold_out;
                  end
                  if (req.last) begin
                     state_in = finish_state;
                  end
               end
            end
         end
         S_ZERO: begin
            acc_in = fold_out;
            ptr_in = CW'(1);
            if (count_ff == '0) begin
               ptr_in     = '0;
               data_ph_in = 1'b1;
               state_in   = S_PEND;
            end else begin
               state_in = S_REPLAY;
            end
         end
         S_REPLAY: begin
            fold_sym = ram_rdata;
            acc_in   = fold_out;
            if (ptr_ff == count_ff) begin
               ptr_in     = '0;
               data_ph_in = 1'b1;
               state_in   = S_PEND;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end
         S_PEND: begin
            if (pend_data_ff) begin
               if (pend_val_ff[VALUE_W-1:SYMBOL_W] != 2'b00) begin
                  err_in = 1'b1;
               end else begin
                  fold_sym = pend_val_ff[SYMBOL_W-1:0];
                  acc_in   = fold_out;
               end
            end
            state_in = pend_last_ff ? finish_state : S_IDLE;
         end
         S_TAIL: begin
            acc_in = fold_out;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               acc_in   = fold_out ^ fc_ff;
               cnt_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               serr_in      = err_ff;
               if (mode_ff == MODE_CREATE) begin
                  sym_in = acc_ff[ACC_W-1:ACC_W-SYMBOL_W];
                  ok_in  = 1'b0;
                  acc_in = {acc_ff[ACC_W-SYMBOL_W-1:0], {SYMBOL_W{1'b0}}};
                  eor    = (cnt_ff == 3'd5);
                  cnt_in = cnt_ff + 3'd1;
               end else begin
                  sym_in = '0;
                  ok_in  = (acc_ff == fc_ff);
                  eor    = 1'b1;
               end
               eor_in = eor;
               if (eor) begin
                  acc_in     = ACC_INIT;
                  count_in   = '0;
                  data_ph_in = 1'b0;
                  err_in     = 1'b0;
                  cnt_in     = '0;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= ACC_INIT;
         count_ff     <= '0;
         ptr_ff       <= '0;
         data_ph_ff   <= 1'b0;
         err_ff       <= 1'b0;
         pend_data_ff <= 1'b0;
         pend_last_ff <= 1'b0;
         cnt_ff       <= '0;
         mode_ff      <= MODE_VERIFY;
         fc_ff        <= FINAL_CONSTANT_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         data_ph_ff   <= data_ph_in;
         err_ff       <= err_in;
         pend_data_ff <= pend_data_in;
         pend_last_ff <= pend_last_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_val_ff <= pend_val_in;
      sym_ff      <= sym_in;
      ok_ff       <= ok_in;
      serr_ff     <= serr_in;
      eor_ff      <= eor_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.symbol      = sym_ff;
   assign rsp.checksum_ok = ok_ff;
   assign rsp.seq_error   = serr_ff;
   assign rsp.end_of_run  = eor_ff;

endmodule

`default_nettype wire

// ===== bench/tb_bech32m_checksum.sv =====
module tb_bech32m_checksum;
   timeunit 1ns;
   timeprecision 1ps;

   import b32m_pkg::*;

   localparam int HRP_MAX     = 83;
   localparam int HALF_PERIOD = 4;
   localparam int SETTLE      = 2 * HRP_MAX + 40;
   localparam int PHASE_WORDS = 21;
   localparam int N_DIRECTED  = 21;
   localparam int N_PHASES    = 7;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                ok;
      logic                err;
      logic                eor;
   } result_word_type;

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               typed;
      logic               ok;
      logic               err;
   } dir_row_type;

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] value;
   } str_word_type;

   // directed words, verify mode with the reset constant
   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      {CMD_PREFIX, 7'd97,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd31,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd9,   1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd19,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd17,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd29,  1'b1, 1'b1, 1'b1, 1'b0},
      {CMD_DATA,   7'd0,   1'b1, 1'b0, 1'b0, 1'b0},
      {CMD_PREFIX, 7'd127, 1'b1, 1'b0, 1'b0, 1'b0},
      {CMD_PREFIX, 7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd31,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_PREFIX, 7'd65,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd127, 1'b1, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd32,  1'b1, 1'b1, 1'b0, 1'b1},
      {CMD_PREFIX, 7'd97,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd31,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd9,   1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd19,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd17,  1'b0, 1'b0, 1'b0, 1'b0},
      {CMD_DATA,   7'd28,  1'b1, 1'b1, 1'b0, 1'b0}
   };

   localparam logic [N_PHASES-1:0] PHASE_MODES = 7'b0101011;
   localparam logic [ACC_W-1:0] PHASE_CONSTS [N_PHASES] = '{
      FINAL_CONSTANT_INIT, 30'd1, 30'd1, 30'd0, 30'h3fffffff, 30'h3fffffff, 30'd0
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MODE;
   logic [ACC_W-1:0]     csr_wdata = '0;

   b32m_req_if req ();
   b32m_rsp_if rsp ();

   bech32m_checksum #(.MAX_PREFIX(HRP_MAX)) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   logic             create_mode;
   logic [ACC_W-1:0] target_const;
   logic [ACC_W-1:0] poly;
   logic [4:0]       hrp_low [HRP_MAX];
   int               hrp_len;
   logic             in_data;
   logic             err_seen;
   result_word_type  words_due [$];
   str_word_type     str_words [$];
   int               words_sent = 0;
   int               mismatches = 0;

   function automatic logic [ACC_W-1:0] polymod_fold(input logic [ACC_W-1:0] a,
                                                     input logic [4:0] sym);
      logic [4:0]       top;
      logic [ACC_W-1:0] r;
      top = a[ACC_W-1 -: 5];
      r = {a[ACC_W-6:0], sym};
      for (int k = 0; k < 5; k++)
         if (top[k])
            r ^= GEN_POLY[k];
      return r;
   endfunction

   task automatic expand_hrp();
      if (!in_data) begin
         poly = polymod_fold(poly, 5'd0);
         for (int k = 0; k < hrp_len; k++)
            poly = polymod_fold(poly, hrp_low[k]);
         in_data = 1'b1;
      end
   endtask

   task automatic track_word(input logic cmd, input logic [VALUE_W-1:0] v, input logic last,
                             input bit keep);
      result_word_type  w;
      logic [ACC_W-1:0] m;
      if (cmd == CMD_PREFIX) begin
         if (in_data || hrp_len >= HRP_MAX) begin
            err_seen = 1'b1;
         end else begin
            poly = polymod_fold(poly, {3'b000, v[6:5]});
            hrp_low[hrp_len] = v[4:0];
            hrp_len++;
         end
      end else begin
         expand_hrp();
         if (v > 31)
            err_seen = 1'b1;
         else
            poly = polymod_fold(poly, v[4:0]);
      end
      if (last) begin
         expand_hrp();
         if (create_mode == MODE_CREATE) begin
            for (int k = 0; k < 6; k++)
               poly = polymod_fold(poly, 5'd0);
            m = poly ^ target_const;
            for (int k = 0; k < 6; k++) begin
               w.symbol = m[5 * (5 - k) +: 5];
               w.ok = 1'b0;
               w.err = err_seen;
               w.eor = (k == 5);
               if (keep)
                  words_due = {words_due, w};
            end
         end else begin
            w.symbol = '0;
            w.ok = (poly == target_const);
            w.err = err_seen;
            w.eor = 1'b1;
            if (keep)
               words_due = {words_due, w};
         end
         poly = ACC_INIT;
         hrp_len = 0;
         in_data = 1'b0;
         err_seen = 1'b0;
      end
   endtask

   // polymod target for a well-formed string built in str_words
   function automatic logic [ACC_W-1:0] checksum_of_words();
      logic [ACC_W-1:0] a;
      a = ACC_INIT;
      foreach (str_words[i])
         if (str_words[i].cmd == CMD_PREFIX)
            a = polymod_fold(a, {3'b000, str_words[i].value[6:5]});
      a = polymod_fold(a, 5'd0);
      foreach (str_words[i])
         if (str_words[i].cmd == CMD_PREFIX)
            a = polymod_fold(a, str_words[i].value[4:0]);
      foreach (str_words[i])
         if (str_words[i].cmd == CMD_DATA)
            a = polymod_fold(a, str_words[i].value[4:0]);
      for (int k = 0; k < 6; k++)
         a = polymod_fold(a, 5'd0);
      return a ^ target_const;
   endfunction

   task automatic report_mismatch(input string what, input result_word_type got,
                                  input result_word_type want);
      mismatches++;
      $display("%0t %s: got sym %0d ok %b err %b end %b, want sym %0d ok %b err %b end %b",
               $time, what, got.symbol, got.ok, got.err, got.eor,
               want.symbol, want.ok, want.err, want.eor);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(input logic cmd, input logic [VALUE_W-1:0] v, input logic last,
                            input int gap);
      repeat (gap) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
      @(negedge clock);
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.value <= v;
      req.last <= last;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      words_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (words_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ACC_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MODE)
         create_mode = data[0];
      else
         target_const = data;
   endtask

   task automatic send_string(input int hrp_force);
      int               n;
      int               idx;
      bit               calm;
      logic [ACC_W-1:0] m;
      str_word_type     w;
      str_words.delete();
      if (hrp_force > 0 || $urandom_range(99) < 75) begin
         if (hrp_force > 0)
            n = hrp_force;
         else
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         for (int i = 0; i < n; i++) begin
            w.cmd = CMD_PREFIX;
            w.value = ($urandom_range(9) == 0) ? VALUE_W'($urandom_range(127)) :
                                                 VALUE_W'($urandom_range(33, 126));
            str_words = {str_words, w};
         end
         n = $urandom_range(12);
         for (int i = 0; i < n; i++) begin
            w.cmd = CMD_DATA;
            w.value = VALUE_W'($urandom_range(31));
            str_words = {str_words, w};
         end
         if (create_mode == MODE_VERIFY && hrp_force <= HRP_MAX && $urandom_range(99) < 70) begin
            m = checksum_of_words();
            for (int k = 0; k < 6; k++) begin
               w.cmd = CMD_DATA;
               w.value = {2'b00, m[5 * (5 - k) +: 5]};
               str_words = {str_words, w};
            end
            // now and then set one random low bit of a checksummed string to the inverse of a random low bit
            if (hrp_force == 0 && $urandom_range(3) == 0) begin
               idx = $urandom_range(str_words.size() - 1);
               w = str_words[idx];
               w.value[$urandom_range(4)] = ~w.value[$urandom_range(4)];
               str_words[idx] = w;
            end
         end
      end else begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++) begin
            w.cmd = 1'($urandom_range(1));
            w.value = VALUE_W'($urandom_range(127));
            str_words = {str_words, w};
         end
      end
      if (str_words.size() == 0) begin
         w.cmd = CMD_PREFIX;
         w.value = VALUE_W'($urandom_range(127));
         str_words = {str_words, w};
      end
      calm = ($urandom_range(3) == 0);
      foreach (str_words[i]) begin
         send_word(str_words[i].cmd, str_words[i].value, i == str_words.size() - 1,
                   calm ? 0 : pick_gap());
         track_word(str_words[i].cmd, str_words[i].value, i == str_words.size() - 1, 1'b1);
      end
   endtask

   // result side back-pressure
   initial begin
      int stall_left;
      int calm_left;
      bit calm;
      stall_left = 0;
      calm_left = 0;
      calm = 1'b0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm_left == 0) begin
            calm_left = $urandom_range(50, 200);
            calm = ($urandom_range(3) == 0);
         end
         calm_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (calm || $urandom_range(99) < 70) begin
            rsp.ready <= 1'b1;
         end else begin
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(2);
            rsp.ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      result_word_type got;
      result_word_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.symbol = rsp.symbol;
         got.ok = rsp.checksum_ok;
         got.err = rsp.seq_error;
         got.eor = rsp.end_of_run;
         if (words_due.size() == 0) begin
            report_mismatch("unexpected word", got, got);
         end else begin
            want = words_due.pop_front();
            if (got.symbol !== want.symbol || got.ok !== want.ok ||
                got.err !== want.err || got.eor !== want.eor)
               report_mismatch("word differs", got, want);
         end
      end
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      result_word_type w;
      int              start;
      req.valid = 1'b0;
      req.cmd = CMD_PREFIX;
      req.value = '0;
      req.last = 1'b0;
      create_mode = MODE_VERIFY;
      target_const = FINAL_CONSTANT_INIT;
      poly = ACC_INIT;
      hrp_len = 0;
      in_data = 1'b0;
      err_seen = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_word(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].last, pick_gap());
         track_word(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].last, !DIRECTED[i].typed);
         if (DIRECTED[i].typed) begin
            w.symbol = '0;
            w.ok = DIRECTED[i].ok;
            w.err = DIRECTED[i].err;
            w.eor = 1'b1;
            words_due = {words_due, w};
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         if (p == N_PHASES - 1) begin
            write_csr(CSR_MODE, ACC_W'($urandom_range(1)));
            write_csr(CSR_FINAL_CONSTANT, ACC_W'($urandom));
         end else begin
            write_csr(CSR_MODE, ACC_W'(PHASE_MODES[p]));
            write_csr(CSR_FINAL_CONSTANT, PHASE_CONSTS[p]);
         end
         start = words_sent;
         // overlong prefix, and a prefix of exactly the maximum length
         if (p == 0)
            send_string(HRP_MAX + 2);
         if (p == 2)
            send_string(HRP_MAX);
         while (words_sent - start < PHASE_WORDS)
            send_string(0);
      end
      drain();

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/b32m_pkg.sv
hdl/b32m_req_if.sv
hdl/b32m_rsp_if.sv
hdl/b32m_ram.sv
hdl/b32m_fold.sv
hdl/bech32m_checksum.sv
bench/tb_bech32m_checksum.sv
